// ----- rtl/core/hcb_pkg.sv -----
// Shared constants, types and command/status structures of the Huffman code builder.
package hcb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W      = 7;
    localparam int LEAF_W      = 6;
    localparam int CNT_W       = 7;
    localparam int WEIGHT_W    = 24;
    localparam int SUM_W       = 30;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 63;
    localparam int LEN_W       = 6;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 80;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        node_t             node;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } walk_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic merge;
        logic walk_init;
        logic child_push;
        logic emit;
        logic pop_read;
        logic pop_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic build_done;
        logic is_leaf;
        logic stack_empty;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/core/hcb_datapath.sv -----
// Datapath of the Huffman code builder: node stores, minimum scan, walk stack and output register.
module hcb_datapath
    import hcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [IN_W-1:0]   in_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [OUT_W-1:0]  out_data,
    output logic              out_last
);

    logic [SYM_W-1:0]  sym_mem   [MAX_SYMBOLS];
    logic [SUM_W-1:0]  wgt_mem   [NODE_COUNT];
    node_t             left_mem  [MAX_SYMBOLS-1];
    node_t             right_mem [MAX_SYMBOLS-1];
    walk_t             stack_mem [MAX_SYMBOLS];

    logic [NODE_COUNT-1:0] alive_reg, alive_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    node_t                 next_reg, next_next;
    walk_t                 cur_reg, cur_next;
    logic [CNT_W-1:0]      sp_reg, sp_next;

    logic                  issue_reg, issue_next;
    node_t                 idx_reg, idx_next;
    logic                  pv_reg, plast_reg, done_reg;
    node_t                 pidx_reg;
    logic                  palive_reg;
    logic [SUM_W-1:0]      wq_reg;
    logic                  have1_reg, have2_reg;
    node_t                 min1_reg, min2_reg;
    logic [SUM_W-1:0]      w1_reg, w2_reg;

    logic [SYM_W-1:0]      sym_q_reg;
    node_t                 lq_reg, rq_reg;
    walk_t                 stk_q_reg;

    logic                  ov_reg;
    logic [SYM_W-1:0]      o_sym_reg;
    logic [CODE_W-1:0]     o_bits_reg;
    logic [LEN_W-1:0]      o_len_reg;
    logic                  o_last_reg;

    logic [LEAF_W-1:0]     merge_slot;
    logic [LEAF_W-1:0]     cur_slot;
    logic [CNT_W:0]        top_node;
    logic [CNT_W-1:0]      sp_dec;
    logic [CODE_W-1:0]     shifted;

    assign merge_slot = LEAF_W'(next_reg - count_reg);
    assign cur_slot   = LEAF_W'(cur_reg.node - count_reg);
    assign top_node   = {count_reg, 1'b0} - (CNT_W+1)'(1);
    assign sp_dec     = sp_reg - CNT_W'(1);
    assign shifted    = {cur_reg.bits[CODE_W-2:0], 1'b0};

    assign stat.scan_done   = done_reg;
    assign stat.build_done  = ({1'b0, next_reg} >= top_node);
    assign stat.is_leaf     = (cur_reg.node < count_reg);
    assign stat.stack_empty = (sp_reg == '0);
    assign stat.out_free    = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign out_data  = {3'b000, o_len_reg, o_bits_reg, o_sym_reg};
    assign out_last  = o_last_reg;

    always_comb
    begin
        alive_next = alive_reg;
        count_next = count_reg;
        next_next  = next_reg;
        cur_next   = cur_reg;
        sp_next    = sp_reg;
        issue_next = issue_reg;
        idx_next   = idx_reg;
        if (cmd.load && count_reg < CNT_W'(MAX_SYMBOLS))
        begin
            alive_next[count_reg] = 1'b1;
            count_next = count_reg + CNT_W'(1);
            next_next  = count_reg + CNT_W'(1);
        end
        if (cmd.scan_start)
        begin
            issue_next = 1'b1;
            idx_next   = '0;
        end
        else if (issue_reg)
        begin
            idx_next = idx_reg + NODE_W'(1);
            if (idx_reg == next_reg - NODE_W'(1))
            begin
                issue_next = 1'b0;
            end
        end
        if (cmd.merge)
        begin
            alive_next[min1_reg] = 1'b0;
            alive_next[min2_reg] = 1'b0;
            alive_next[next_reg] = 1'b1;
            next_next = next_reg + NODE_W'(1);
        end
        if (cmd.walk_init)
        begin
            cur_next.node = next_reg - NODE_W'(1);
            cur_next.bits = '0;
            cur_next.len  = '0;
            sp_next       = '0;
        end
        if (cmd.child_push)
        begin
            cur_next.node = lq_reg;
            cur_next.bits = shifted;
            cur_next.len  = cur_reg.len + LEN_W'(1);
            sp_next       = sp_reg + CNT_W'(1);
        end
        if (cmd.pop_read)
        begin
            sp_next = sp_dec;
        end
        if (cmd.pop_load)
        begin
            cur_next = stk_q_reg;
        end
        if (cmd.clear)
        begin
            alive_next = '0;
            count_next = '0;
            next_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '0;
            count_reg <= '0;
            next_reg  <= '0;
            sp_reg    <= '0;
            issue_reg <= 1'b0;
            idx_reg   <= '0;
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
            ov_reg    <= 1'b0;
            cur_reg   <= '0;
        end
        else
        begin
            alive_reg <= alive_next;
            count_reg <= count_next;
            next_reg  <= next_next;
            sp_reg    <= sp_next;
            cur_reg   <= cur_next;
            issue_reg <= issue_next;
            idx_reg   <= idx_next;
            pv_reg    <= issue_reg && !cmd.scan_start;
            plast_reg <= (idx_reg == next_reg - NODE_W'(1));
            done_reg  <= pv_reg && plast_reg;
            if (cmd.scan_start)
            begin
                have1_reg <= 1'b0;
                have2_reg <= 1'b0;
            end
            else if (pv_reg && palive_reg)
            begin
                // Ascending scan with strict compares keeps ties on the lower index.
                if (!have1_reg || wq_reg < w1_reg)
                begin
                    have1_reg <= 1'b1;
                    have2_reg <= have1_reg;
                end
                else if (!have2_reg || wq_reg < w2_reg)
                begin
                    have2_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg   <= idx_reg;
        palive_reg <= alive_reg[idx_reg];
        wq_reg     <= wgt_mem[idx_reg];
        if (pv_reg && palive_reg)
        begin
            if (!have1_reg || wq_reg < w1_reg)
            begin
                min2_reg <= min1_reg;
                w2_reg   <= w1_reg;
                min1_reg <= pidx_reg;
                w1_reg   <= wq_reg;
            end
            else if (!have2_reg || wq_reg < w2_reg)
            begin
                min2_reg <= pidx_reg;
                w2_reg   <= wq_reg;
            end
        end
        if (cmd.load && count_reg < CNT_W'(MAX_SYMBOLS))
        begin
            sym_mem[count_reg[LEAF_W-1:0]] <= in_data[SYM_W-1:0];
            wgt_mem[count_reg] <= SUM_W'(in_data[SYM_W +: WEIGHT_W]);
        end
        else if (cmd.merge)
        begin
            wgt_mem[next_reg] <= w1_reg + w2_reg;
        end
        if (cmd.merge)
        begin
            left_mem[merge_slot]  <= min1_reg;
            right_mem[merge_slot] <= min2_reg;
        end
        sym_q_reg <= sym_mem[cur_reg.node[LEAF_W-1:0]];
        lq_reg    <= left_mem[cur_slot];
        rq_reg    <= right_mem[cur_slot];
        if (cmd.child_push)
        begin
            stack_mem[sp_reg[LEAF_W-1:0]] <= '{node: rq_reg, bits: shifted | CODE_W'(1),
                                              len: cur_reg.len + LEN_W'(1)};
        end
        stk_q_reg <= stack_mem[sp_dec[LEAF_W-1:0]];
        if (cmd.emit)
        begin
            o_sym_reg  <= sym_q_reg;
            o_bits_reg <= cur_reg.bits;
            o_len_reg  <= cur_reg.len;
            o_last_reg <= (sp_reg == '0);
        end
    end

endmodule

// ----- rtl/core/hcb_ctrl.sv -----
// Sequencer of the Huffman code builder: loading, merge loop, tree walk and clean-up.
module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_last,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_BUILD_CHK = 4'd1;
    localparam logic [3:0] S_SCAN_WAIT = 4'd2;
    localparam logic [3:0] S_MERGE     = 4'd3;
    localparam logic [3:0] S_WALK_INIT = 4'd4;
    localparam logic [3:0] S_EVAL      = 4'd5;
    localparam logic [3:0] S_CHILD     = 4'd6;
    localparam logic [3:0] S_LEAF      = 4'd7;
    localparam logic [3:0] S_POP       = 4'd8;
    localparam logic [3:0] S_POP_LOAD  = 4'd9;
    localparam logic [3:0] S_CLEAR     = 4'd10;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_BUILD_CHK;
                    end
                end
            end
            S_BUILD_CHK:
            begin
                if (stat.build_done)
                begin
                    state_next = S_WALK_INIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = S_BUILD_CHK;
            end
            S_WALK_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = stat.is_leaf ? S_LEAF : S_CHILD;
            end
            S_CHILD:
            begin
                cmd.child_push = 1'b1;
                state_next     = S_EVAL;
            end
            S_LEAF:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.stack_empty ? S_CLEAR : S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop_read = 1'b1;
                state_next   = S_POP_LOAD;
            end
            S_POP_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_EVAL;
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/huffman_code_builder_unit.sv -----
// Top level of the Huffman code builder: sequencer and datapath joined.
//
//  Channel   Direction  Payload
//  s_*       in         tdata = symbol[7:0], weight[31:8]; tlast = last_entry
//  m_*       out        tdata = code_symbol[7:0], code_word[70:8], code_length[76:71],
//                       zero fill [79:77]; tlast = last_code
//
// Loading accepts one entry per cycle. After the closing request the build
// makes n-1 merges, each after a scan of the weight memory, through its single
// read port, over every node below the next free one. The tree walk then pushes
// the children of each internal node and emits each leaf's code. Reset needs no
// clearing pass. A stalled output holds the walk until the code register is taken.
module huffman_code_builder_unit
    import hcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // symbol, weight
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // code_symbol, code_word, code_length, zero fill
    output logic              m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    hcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hcb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
